@@ hdl/prts_pkg.sv @@
package prts_pkg;

  localparam int ID_BITS          = 6;
  localparam int TYPE_BITS        = 2;
  localparam int MAX_ENTITIES_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;

  typedef enum logic [TYPE_BITS-1:0] {
    REQ_UPDATE = 2'd0,
    REQ_READ   = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_NONE   = 2'd3
  } req_kind_t;

  // classified request handed from the front queue to the back end
  typedef struct packed {
    req_kind_t            kind;
    logic                 in_tbl;
    logic [ID_BITS-1:0]   id;
  } req_cmd_t;

endpackage

@@ hdl/prts_front.sv @@
module prts_front #(
  parameter int MAX_ENTITIES = prts_pkg::MAX_ENTITIES_DEF,
  parameter int COORD_BITS   = prts_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [prts_pkg::TYPE_BITS-1:0]   in_type,
  input  logic [prts_pkg::ID_BITS-1:0]     in_id,
  input  logic [COORD_BITS-1:0]            in_x,
  input  logic [COORD_BITS-1:0]            in_y,
  input  logic [COORD_BITS-1:0]            in_rad,
  output logic                             q_valid,
  output prts_pkg::req_cmd_t               q_cmd,
  output logic [COORD_BITS-1:0]            q_x,
  output logic [COORD_BITS-1:0]            q_y,
  output logic [COORD_BITS-1:0]            q_rad,
  input  logic                             q_pop
);

  localparam int QD   = 2;
  localparam int QP_W = $clog2(QD);
  localparam int QC_W = $clog2(QD + 1);

  prts_pkg::req_cmd_t      cmd_r [QD];
  logic [COORD_BITS-1:0]   qx_r  [QD];
  logic [COORD_BITS-1:0]   qy_r  [QD];
  logic [COORD_BITS-1:0]   qr_r  [QD];
  logic [QP_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]         cnt_r, cnt_nxt;

  prts_pkg::req_cmd_t      cls;
  logic                    keep;
  logic                    push;

  // classify: drop unused type and updates that fall outside the table
  always_comb begin
    cls.kind   = prts_pkg::req_kind_t'(in_type);
    cls.id     = in_id;
    cls.in_tbl = ({1'b0, in_id} < (prts_pkg::ID_BITS + 1)'(MAX_ENTITIES));
    keep       = (cls.kind != prts_pkg::REQ_NONE) &&
                 !((cls.kind == prts_pkg::REQ_UPDATE) && !cls.in_tbl);
  end

  assign in_ready = (cnt_r != QC_W'(QD));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = cmd_r[rd_ptr_r];
  assign q_x      = qx_r[rd_ptr_r];
  assign q_y      = qy_r[rd_ptr_r];
  assign q_rad    = qr_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + QP_W'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + QP_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QC_W'(push) - QC_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_r[wr_ptr_r] <= cls;
      qx_r[wr_ptr_r]  <= in_x;
      qy_r[wr_ptr_r]  <= in_y;
      qr_r[wr_ptr_r]  <= in_rad;
    end
  end

endmodule

@@ hdl/prts_back.sv @@
module prts_back #(
  parameter int MAX_ENTITIES = prts_pkg::MAX_ENTITIES_DEF,
  parameter int COORD_BITS   = prts_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  prts_pkg::req_cmd_t             q_cmd,
  input  logic [COORD_BITS-1:0]          q_x,
  input  logic [COORD_BITS-1:0]          q_y,
  input  logic [COORD_BITS-1:0]          q_rad,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_found,
  output logic [COORD_BITS-1:0]          out_x,
  output logic [COORD_BITS-1:0]          out_y,
  output logic [prts_pkg::ID_BITS-1:0]   out_nid,
  output logic                           out_last
);

  localparam int CB    = COORD_BITS;
  localparam int IDX_W = $clog2(MAX_ENTITIES);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_RDWAIT = 5'b00010,
    ST_CENTER = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_FLUSH  = 5'b10000
  } bst_t;

  bst_t                    state_r, state_nxt;

  logic [2*CB-1:0]         mem_r [MAX_ENTITIES];
  logic [2*CB-1:0]         rd_q_r;
  logic [MAX_ENTITIES-1:0] vld_r;
  logic [IDX_W-1:0]        mem_addr;
  logic                    mem_we;

  logic [IDX_W-1:0]        hidx;
  logic                    hit;

  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    iss_r, iss_nxt;
  logic                    issue;
  logic                    idx_end;
  logic [IDX_W-1:0]        cid_r;
  logic [CB-1:0]           rad_r;
  logic [2*CB-1:0]         r2_r;
  logic [CB-1:0]           cx_r, cy_r;

  // scan pipeline: read data, abs diffs, squares
  logic                    p1_v_r, p1_cand_r, p1_end_r;
  logic [IDX_W-1:0]        p1_id_r;
  logic                    p2_v_r, p2_cand_r, p2_end_r;
  logic [IDX_W-1:0]        p2_id_r;
  logic [CB-1:0]           dx_r, dy_r;
  logic                    p3_v_r, p3_cand_r, p3_end_r;
  logic [IDX_W-1:0]        p3_id_r;
  logic [2*CB-1:0]         dx2_r, dy2_r;

  logic [CB-1:0]           rd_x, rd_y;
  logic [CB-1:0]           dx, dy;
  logic [2*CB-1:0]         dx_sq, dy_sq;
  logic [2*CB:0]           dist2;
  logic                    match;

  // one match is held back so the final one can carry last
  logic                    pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]        pend_id_r, pend_id_nxt;

  logic                    adv;
  logic                    emit;
  logic                    e_found, e_last;
  logic [CB-1:0]           e_x, e_y;
  logic [IDX_W-1:0]        e_nid;

  logic                    out_valid_r;
  logic                    out_found_r, out_last_r;
  logic [CB-1:0]           out_x_r, out_y_r;
  logic [prts_pkg::ID_BITS-1:0] out_nid_r;

  // the whole back end steps only when the output register can take a word
  assign adv      = !out_valid_r || out_ready;
  assign hidx     = q_cmd.id[IDX_W-1:0];
  assign hit      = q_cmd.in_tbl && vld_r[hidx];
  assign mem_addr = (state_r == ST_IDLE) ? hidx : idx_r;
  assign issue    = iss_r && ((state_r == ST_CENTER) || (state_r == ST_SCAN));
  assign idx_end  = (idx_r == IDX_W'(MAX_ENTITIES - 1));

  assign rd_x  = rd_q_r[CB-1:0];
  assign rd_y  = rd_q_r[2*CB-1:CB];
  assign dx    = (rd_x >= cx_r) ? rd_x - cx_r : cx_r - rd_x;
  assign dy    = (rd_y >= cy_r) ? rd_y - cy_r : cy_r - rd_y;
  assign dx_sq = dx_r * dx_r;
  assign dy_sq = dy_r * dy_r;
  assign dist2 = {1'b0, dx2_r} + {1'b0, dy2_r};
  assign match = p3_cand_r && (dist2 <= {1'b0, r2_r});

  always_comb begin
    state_nxt   = state_r;
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    emit        = 1'b0;
    e_found     = 1'b0;
    e_last      = 1'b0;
    e_x         = '0;
    e_y         = '0;
    e_nid       = '0;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    idx_nxt     = idx_r;
    iss_nxt     = iss_r;
    if (adv) begin
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            q_pop = 1'b1;
            case (q_cmd.kind)
              prts_pkg::REQ_UPDATE: begin
                mem_we = q_cmd.in_tbl;
              end
              prts_pkg::REQ_READ: begin
                if (hit) begin
                  state_nxt = ST_RDWAIT;
                end else begin
                  emit   = 1'b1;
                  e_last = 1'b1;
                end
              end
              prts_pkg::REQ_SEARCH: begin
                if (hit) begin
                  state_nxt  = ST_CENTER;
                  idx_nxt    = '0;
                  iss_nxt    = 1'b1;
                  pend_v_nxt = 1'b0;
                end else begin
                  emit   = 1'b1;
                  e_last = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_RDWAIT: begin
          emit      = 1'b1;
          e_found   = 1'b1;
          e_last    = 1'b1;
          e_x       = rd_x;
          e_y       = rd_y;
          state_nxt = ST_IDLE;
        end
        ST_CENTER: begin
          state_nxt = ST_SCAN;
        end
        ST_SCAN: begin
          if (p3_v_r) begin
            if (match) begin
              emit        = pend_v_r;
              e_found     = 1'b1;
              e_nid       = pend_id_r;
              pend_v_nxt  = 1'b1;
              pend_id_nxt = p3_id_r;
            end
            if (p3_end_r) begin
              state_nxt = ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          emit       = 1'b1;
          e_found    = pend_v_r;
          e_nid      = pend_v_r ? pend_id_r : '0;
          e_last     = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
      if (issue) begin
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_end) begin
          iss_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      iss_r       <= 1'b0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      iss_r    <= iss_nxt;
      idx_r    <= idx_nxt;
      pend_v_r <= pend_v_nxt;
      if (mem_we) begin
        vld_r[hidx] <= 1'b1;
      end
      if (adv) begin
        p1_v_r <= issue;
        p2_v_r <= p1_v_r;
        p3_v_r <= p2_v_r;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[hidx] <= {q_y, q_x};
    end
    if (adv) begin
      rd_q_r <= mem_r[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r <= pend_id_nxt;
    if (q_pop) begin
      cid_r <= hidx;
      rad_r <= q_rad;
    end
    if (adv) begin
      if (state_r == ST_CENTER) begin
        cx_r <= rd_x;
        cy_r <= rd_y;
        r2_r <= rad_r * rad_r;
      end
      p1_cand_r <= vld_r[idx_r] && (idx_r != cid_r);
      p1_end_r  <= idx_end;
      p1_id_r   <= idx_r;
      p2_cand_r <= p1_cand_r;
      p2_end_r  <= p1_end_r;
      p2_id_r   <= p1_id_r;
      dx_r      <= dx;
      dy_r      <= dy;
      p3_cand_r <= p2_cand_r;
      p3_end_r  <= p2_end_r;
      p3_id_r   <= p2_id_r;
      dx2_r     <= dx_sq;
      dy2_r     <= dy_sq;
    end
    if (emit) begin
      out_found_r <= e_found;
      out_last_r  <= e_last;
      out_x_r     <= e_x;
      out_y_r     <= e_y;
      out_nid_r   <= prts_pkg::ID_BITS'(e_nid);
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_last  = out_last_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_nid   = out_nid_r;

endmodule

@@ hdl/position_table_radius_search_top.sv @@
// Position table with fixed-radius neighbor search.
// Input stream: one word per request. in_tuser carries the request type
// (update, read, search); in_tdata carries id, x, y and radius.
// Output stream: out_tuser is the found flag, out_tlast marks the final word
// of a request, out_tdata carries x, y and the neighbor id.
// An update gives no output word. A read gives one word. A search gives one
// word per neighbor in ascending id order, or one empty word if none match.
// In the back end, an update or any miss is handled straight from idle, and a
// read hit goes through a read-wait state. In a search hit the center entry is
// fetched, the table is swept one entry per cycle (while the output is not
// stalled) through its single read port, a three-stage distance pipeline
// drains, and the held-back final word goes out.
// A two-word request queue sits in front, so input is taken while a search
// runs or while the output register waits.
// Reset empties the table (all entries invalid) and drops queued requests.
// A stalled receiver freezes the back end in place; nothing is lost, and the
// input side keeps accepting until the queue is full.
module position_table_radius_search_top #(
  parameter int MAX_ENTITIES = prts_pkg::MAX_ENTITIES_DEF,
  parameter int COORD_BITS   = prts_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [prts_pkg::TYPE_BITS-1:0]   in_tuser,  // req_type
  // entity_id, pos_x, pos_y, search_radius
  input  logic [((prts_pkg::ID_BITS + 3*COORD_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic                             out_tuser, // found
  output logic                             out_tlast,
  // out_x, out_y, neighbor_id
  output logic [((prts_pkg::ID_BITS + 2*COORD_BITS + 7) / 8) * 8 - 1:0] out_tdata
);

  localparam int CB      = COORD_BITS;
  localparam int IDB     = prts_pkg::ID_BITS;
  localparam int OUT_W   = ((IDB + 2*CB + 7) / 8) * 8;

  logic                    q_valid;
  logic                    q_pop;
  prts_pkg::req_cmd_t      q_cmd;
  logic [CB-1:0]           q_x, q_y, q_rad;
  logic [CB-1:0]           res_x, res_y;
  logic [IDB-1:0]          res_nid;

  prts_front #(
    .MAX_ENTITIES (MAX_ENTITIES),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_type  (in_tuser),
    .in_id    (in_tdata[IDB-1:0]),
    .in_x     (in_tdata[IDB+CB-1:IDB]),
    .in_y     (in_tdata[IDB+2*CB-1:IDB+CB]),
    .in_rad   (in_tdata[IDB+3*CB-1:IDB+2*CB]),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_x      (q_x),
    .q_y      (q_y),
    .q_rad    (q_rad),
    .q_pop    (q_pop)
  );

  prts_back #(
    .MAX_ENTITIES (MAX_ENTITIES),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_x       (q_x),
    .q_y       (q_y),
    .q_rad     (q_rad),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_found (out_tuser),
    .out_x     (res_x),
    .out_y     (res_y),
    .out_nid   (res_nid),
    .out_last  (out_tlast)
  );

  assign out_tdata = OUT_W'({res_nid, res_y, res_x});

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back end popped an empty request queue");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tlast)
    else $error("not-found word without last");

  a_mid_is_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tuser && (res_x == '0) && (res_y == '0)))
    else $error("non-final word is not a clean neighbor word");

endmodule

@@ tb/position_table_radius_search_top_tb.sv @@
module position_table_radius_search_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W   = prts_pkg::COORD_BITS_DEF;
  localparam int IDB       = prts_pkg::ID_BITS;
  localparam int IN_W      = ((IDB + 3*COORD_W + 7) / 8) * 8;
  localparam int OUT_W     = ((IDB + 2*COORD_W + 7) / 8) * 8;
  localparam int N_ENT     = prts_pkg::MAX_ENTITIES_DEF;
  localparam int HOLD_LEN  = 400;
  localparam int STALL_MAX = 4000;
  localparam int TAIL_LEN  = 100;

  typedef struct {
    prts_pkg::req_kind_t kind;
    logic [IDB-1:0]      id;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  radius;
  } pos_req_t;

  typedef struct {
    logic                found;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [IDB-1:0]      nid;
    logic                last;
  } resp_word_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [prts_pkg::TYPE_BITS-1:0] in_tuser = '0;
  logic [IN_W-1:0]                in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic                           out_tuser;
  logic                           out_tlast;
  logic [OUT_W-1:0]               out_tdata;

  position_table_radius_search_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pos_req_t   pending_reqs[$];
  resp_word_t expected_words[$];

  // shadow copy of the position table
  logic               tbl_valid [N_ENT];
  logic [COORD_W-1:0] tbl_x     [N_ENT];
  logic [COORD_W-1:0] tbl_y     [N_ENT];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_reqs      = 0;
  int hold_taken;
  int hold_cnt;
  int mismatches     = 0;
  int quiet_cycles   = 0;
  pos_req_t next_req;

  function automatic void push_word(logic found, logic [COORD_W-1:0] x,
                                    logic [COORD_W-1:0] y, logic [IDB-1:0] nid,
                                    logic last);
    resp_word_t w;
    w.found = found;
    w.x     = x;
    w.y     = y;
    w.nid   = nid;
    w.last  = last;
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void predict_table_request(pos_req_t r);
    logic [IDB-1:0] hits[$];
    longint unsigned r2, dx, dy;
    case (r.kind)
      prts_pkg::REQ_UPDATE: begin
        tbl_valid[r.id] = 1'b1;
        tbl_x[r.id]     = r.x;
        tbl_y[r.id]     = r.y;
      end
      prts_pkg::REQ_READ: begin
        if (tbl_valid[r.id]) push_word(1'b1, tbl_x[r.id], tbl_y[r.id], '0, 1'b1);
        else push_word(1'b0, '0, '0, '0, 1'b1);
      end
      prts_pkg::REQ_SEARCH: begin
        if (tbl_valid[r.id]) begin
          r2 = longint'(r.radius) * longint'(r.radius);
          for (int i = 0; i < N_ENT; i++) begin
            if (i != r.id && tbl_valid[i]) begin
              dx = (tbl_x[i] >= tbl_x[r.id]) ? tbl_x[i] - tbl_x[r.id] : tbl_x[r.id] - tbl_x[i];
              dy = (tbl_y[i] >= tbl_y[r.id]) ? tbl_y[i] - tbl_y[r.id] : tbl_y[r.id] - tbl_y[i];
              if (dx*dx + dy*dy <= r2) hits.insert(hits.size(), IDB'(i));
            end
          end
        end
        if (hits.size() == 0) push_word(1'b0, '0, '0, '0, 1'b1);
        else foreach (hits[k]) push_word(1'b1, '0, '0, hits[k], k == hits.size() - 1);
      end
      default: ;  // unused type: ignored
    endcase
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  function automatic void add_req(prts_pkg::req_kind_t kind, int id, int x, int y,
                                  int radius);
    pos_req_t r;
    r.kind   = kind;
    r.id     = IDB'(id);
    r.x      = COORD_W'(x);
    r.y      = COORD_W'(y);
    r.radius = COORD_W'(radius);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // clustered coords so that searches find neighbors
  function automatic int rand_coord();
    case ($urandom_range(9))
      0: return 0;
      1: return 65535;
      2, 3: return $urandom_range(65535);
      default: return 30000 + $urandom_range(500);
    endcase
  endfunction

  function automatic void add_random_req(int search_pct);
    int sel, id, radius;
    prts_pkg::req_kind_t kind;
    sel = $urandom_range(99);
    if (sel < search_pct) kind = prts_pkg::REQ_SEARCH;
    else if (sel < search_pct + 40) kind = prts_pkg::REQ_UPDATE;
    else if (sel < 95) kind = prts_pkg::REQ_READ;
    else kind = prts_pkg::REQ_NONE;
    id = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(15);
    case ($urandom_range(7))
      0: radius = 0;
      1: radius = 65535;
      2: radius = $urandom_range(65535);
      default: radius = $urandom_range(600);
    endcase
    add_req(kind, id, rand_coord(), rand_coord(), radius);
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        in_tuser  <= next_req.kind;
        in_tdata  <= {{(IN_W - IDB - 3*COORD_W){1'b0}},
                      next_req.radius, next_req.y, next_req.x, next_req.id};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt   <= 0;
      hold_taken <= 0;
    end else if (hold_taken != hold_reqs) begin
      hold_taken <= hold_reqs;
      hold_cnt   <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt   <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // accepted request word -> expected results
  always @(posedge clk) begin
    pos_req_t r;
    if (rst_n && in_tvalid && in_tready) begin
      r.kind   = prts_pkg::req_kind_t'(in_tuser);
      r.id     = in_tdata[IDB-1:0];
      r.x      = in_tdata[IDB +: COORD_W];
      r.y      = in_tdata[IDB + COORD_W +: COORD_W];
      r.radius = in_tdata[IDB + 2*COORD_W +: COORD_W];
      predict_table_request(r);
    end
  end

  // accepted result word vs oldest expectation
  always @(posedge clk) begin
    resp_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t unexpected word: expected none actual found=%0b data=%0h last=%0b",
                   $time, out_tuser, out_tdata, out_tlast);
      end else begin
        want = expected_words.pop_front();
        check_field("found", want.found, out_tuser);
        check_field("out_x", want.x, out_tdata[COORD_W-1:0]);
        check_field("out_y", want.y, out_tdata[COORD_W +: COORD_W]);
        check_field("neighbor_id", want.nid, out_tdata[2*COORD_W +: IDB]);
        check_field("last", want.last, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
        $display("%0t no progress for %0d cycles", $time, quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || in_tvalid || expected_words.size() > 0)
      @(negedge clk);
  endtask

  task automatic random_phase(int count, int s_pct, int r_pct);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    repeat (count) add_random_req(30);
    drain();
  endtask

  initial begin
    foreach (tbl_valid[i]) begin
      tbl_valid[i] = 1'b0;
      tbl_x[i]     = '0;
      tbl_y[i]     = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, extremes, exact-radius boundary, ignored type
    add_req(prts_pkg::REQ_READ, 0, 0, 0, 0);
    add_req(prts_pkg::REQ_SEARCH, 5, 0, 0, 65535);
    add_req(prts_pkg::REQ_NONE, 7, 65535, 65535, 65535);
    add_req(prts_pkg::REQ_READ, 7, 0, 0, 0);
    add_req(prts_pkg::REQ_UPDATE, 0, 0, 0, 0);
    add_req(prts_pkg::REQ_UPDATE, 63, 65535, 65535, 65535);
    add_req(prts_pkg::REQ_UPDATE, 1, 3, 4, 0);
    add_req(prts_pkg::REQ_UPDATE, 2, 65535, 0, 0);
    add_req(prts_pkg::REQ_UPDATE, 3, 0, 65535, 0);
    add_req(prts_pkg::REQ_READ, 0, 0, 0, 0);
    add_req(prts_pkg::REQ_READ, 63, 0, 0, 0);
    add_req(prts_pkg::REQ_READ, 1, 0, 0, 0);
    add_req(prts_pkg::REQ_SEARCH, 0, 0, 0, 5);       // distance exactly 5 matches
    add_req(prts_pkg::REQ_SEARCH, 0, 0, 0, 4);
    add_req(prts_pkg::REQ_SEARCH, 0, 0, 0, 65535);
    add_req(prts_pkg::REQ_SEARCH, 63, 0, 0, 0);
    add_req(prts_pkg::REQ_UPDATE, 4, 65535, 65535, 0);
    add_req(prts_pkg::REQ_SEARCH, 63, 0, 0, 0);      // coincident neighbor at radius 0
    add_req(prts_pkg::REQ_UPDATE, 1, 1, 1, 0);
    add_req(prts_pkg::REQ_NONE, 1, 500, 500, 500);
    add_req(prts_pkg::REQ_READ, 1, 0, 0, 0);
    add_req(prts_pkg::REQ_SEARCH, 1, 65535, 65535, 65535);
    drain();

    // fill the table a bit so random searches have company
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (12) add_req(prts_pkg::REQ_UPDATE, $urandom_range(15),
                        30000 + $urandom_range(500), 30000 + $urandom_range(500), 0);
    drain();

    random_phase(35, 0, 0);
    random_phase(35, 57, 0);
    random_phase(35, 0, 57);
    random_phase(35, 28, 28);

    // long receiver hold-off while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_reqs      = hold_reqs + 1;
    repeat (20) add_random_req(60);
    drain();

    repeat (TAIL_LEN) @(negedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
